@@ rtl/wssd_pkg.sv @@
// Shared types and constants for the windowed sum of squared differences block.
// Used by wssd_front, wssd_back and windowed_sum_squared_difference.
`timescale 1ns / 1ps

package wssd_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_WINDOW = 20;
  localparam int MAX_HEIGHT = 1024;

  localparam int DIM_W  = 11;  // width, height and counters that can reach 1024
  localparam int COL_W  = 10;  // column or row index inside the frame
  localparam int WIN_W  = 5;
  localparam int HALF_W = 4;
  localparam int POS_W  = 21;  // word position inside one frame stream
  localparam int SQ_W   = 32;
  localparam int CS_W   = 39;
  localparam int SSD_W  = 41;
  localparam int PIX_W  = 16;
  localparam int CFG_W  = 11;
  localparam int IDX_W  = 2;

  // Rows of squared differences kept in the store; a power of two so the slot
  // is the low bits of the row number.
  localparam int STORE_ROWS = 32;
  localparam int SLOT_W     = 5;

  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = 2;
  localparam int QCNT_W   = 3;
  localparam int OQ_DEPTH = 4;

  localparam logic [IDX_W-1:0] CFG_WINDOW = 2'd0;
  localparam logic [IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [IDX_W-1:0] CFG_HEIGHT = 2'd2;

  // Clamped configuration and the figures derived from it.
  typedef struct packed {
    logic [WIN_W-1:0]  m;
    logic [HALF_W-1:0] half;
    logic [HALF_W-1:0] ahead;
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [POS_W-1:0]  total_last;  // position of the word that ends the frame
  } cfg_t;

  // One classified word on its way from the front to the back.
  typedef struct packed {
    logic [SQ_W-1:0]  sq;
    logic             wr;    // lands inside the frame and goes to the store
    logic [COL_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;  // final word of the frame stream
  } item_t;

endpackage

@@ rtl/wssd_front.sv @@
// Front end: input register, position tracking, squaring and the item queue.
// Depends on wssd_pkg.
`timescale 1ns / 1ps

module wssd_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           restart,
  input  wssd_pkg::cfg_t                 cfg,
  input  logic                           in_push,
  input  logic signed [wssd_pkg::PIX_W-1:0] in_pixel_first,
  input  logic signed [wssd_pkg::PIX_W-1:0] in_pixel_second,
  input  logic                           in_flush,
  output logic                           in_full,
  input  logic                           q_pop,
  output logic                           q_vld,
  output wssd_pkg::item_t                q_head
);

  logic                              s1_vld_r;
  logic signed [wssd_pkg::PIX_W:0]   s1_diff_r;
  logic                              s1_flush_r;
  logic [wssd_pkg::POS_W-1:0]        pos_r;
  logic [wssd_pkg::DIM_W-1:0]        row_r;
  logic [wssd_pkg::COL_W-1:0]        col_r;
  wssd_pkg::item_t                   q_mem_r [wssd_pkg::QDEPTH];
  logic [wssd_pkg::QPTR_W-1:0]       wp_r, rp_r;
  logic [wssd_pkg::QCNT_W-1:0]       cnt_r;

  logic                              accept;
  logic                              surplus;
  logic                              consume;
  logic                              is_last;
  logic                              col_wrap;
  logic signed [2*wssd_pkg::PIX_W+1:0] sq_full;
  wssd_pkg::item_t                   entry;

  assign in_full = ({1'b0, cnt_r} + {{wssd_pkg::QCNT_W{1'b0}}, s1_vld_r})
                   >= (wssd_pkg::QCNT_W+1)'(wssd_pkg::QDEPTH);
  assign accept  = in_push && !in_full;

  // A flush word at the very start of a frame belongs to no frame.
  assign surplus  = s1_flush_r && (pos_r == '0);
  assign consume  = s1_vld_r && !surplus;
  assign is_last  = (pos_r == cfg.total_last);
  assign col_wrap = ({1'b0, col_r} + 11'd1) >= cfg.w;
  assign sq_full  = s1_diff_r * s1_diff_r;

  always_comb begin
    entry      = '0;
    entry.sq   = s1_flush_r ? '0 : sq_full[wssd_pkg::SQ_W-1:0];
    entry.wr   = (row_r < cfg.h);
    entry.row  = row_r[wssd_pkg::COL_W-1:0];
    entry.col  = col_r;
    entry.last = is_last;
  end

  assign q_vld  = (cnt_r != '0);
  assign q_head = q_mem_r[rp_r];

  always_ff @(posedge clk) begin
    s1_diff_r  <= (wssd_pkg::PIX_W+1)'(in_pixel_first) - (wssd_pkg::PIX_W+1)'(in_pixel_second);
    s1_flush_r <= in_flush;
    if (consume) begin
      q_mem_r[wp_r] <= entry;
    end
    if (!rst_n || restart) begin
      s1_vld_r <= 1'b0;
      pos_r    <= '0;
      row_r    <= '0;
      col_r    <= '0;
      wp_r     <= '0;
      rp_r     <= '0;
      cnt_r    <= '0;
    end else begin
      s1_vld_r <= accept;
      if (consume) begin
        if (is_last) begin
          pos_r <= '0;
          row_r <= '0;
          col_r <= '0;
        end else begin
          pos_r <= pos_r + 21'd1;
          if (col_wrap) begin
            col_r <= '0;
            row_r <= row_r + 11'd1;
          end else begin
            col_r <= col_r + 10'd1;
          end
        end
        wp_r <= wp_r + 2'd1;
      end
      if (q_pop) begin
        rp_r <= rp_r + 2'd1;
      end
      cnt_r <= cnt_r + {2'b0, consume} - {2'b0, q_pop};
    end
  end

endmodule

@@ rtl/wssd_back.sv @@
// Back end: square store, column sum sequencer, window sum and result queue.
// Depends on wssd_pkg.
`timescale 1ns / 1ps

module wssd_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         restart,
  input  wssd_pkg::cfg_t               cfg,
  input  logic                         q_vld,
  input  wssd_pkg::item_t              q_head,
  output logic                         q_pop,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [wssd_pkg::SSD_W-1:0]   out_window_ssd,
  output logic                         out_frame_last
);

  localparam int ADDR_W = wssd_pkg::SLOT_W + wssd_pkg::COL_W;

  typedef struct packed {
    logic [wssd_pkg::SSD_W-1:0] ssd;
    logic                       last;
  } res_t;

  logic [wssd_pkg::SQ_W-1:0] sq_mem [wssd_pkg::STORE_ROWS*wssd_pkg::MAX_WIDTH];
  logic [wssd_pkg::CS_W-1:0] cs_mem [wssd_pkg::MAX_WIDTH];

  logic [wssd_pkg::POS_W-1:0] a_r, base_r;
  logic                       hold_r;
  logic [wssd_pkg::DIM_W-1:0] ir_r, x_r;

  logic [wssd_pkg::SQ_W-1:0]  sq_add_q, sq_sub_q;
  logic [wssd_pkg::CS_W-1:0]  cs_q;

  logic                       s2_vld_r, s2_xw_r, s2_add_r, s2_sub_r, s2_first_r;
  logic                       s2_res_r, s2_last_r, s2_x0_r, s2_xm_r;
  logic [wssd_pkg::COL_W-1:0] s2_x_r;

  logic                       fw_vld_r;
  logic [wssd_pkg::COL_W-1:0] fw_x_r;
  logic [wssd_pkg::CS_W-1:0]  fw_v_r;

  logic                       s3_vld_r, s3_res_r, s3_last_r, s3_x0_r, s3_xm_r;
  logic [wssd_pkg::CS_W-1:0]  s3_v_r;
  logic [wssd_pkg::CS_W-1:0]  line_r [wssd_pkg::MAX_WINDOW];
  logic [wssd_pkg::SSD_W-1:0] ssd_r;

  res_t                        oq_mem_r [wssd_pkg::OQ_DEPTH];
  logic [wssd_pkg::QPTR_W-1:0] oq_wp_r, oq_rp_r;
  logic [wssd_pkg::QCNT_W-1:0] oq_cnt_r;

  logic                       virt, x_lt_w, add_en, sub_en, res, frame_end, room, issue;
  logic                       oq_push, oq_take;
  logic [wssd_pkg::DIM_W-1:0] last_x, irm, last_ir;
  logic [wssd_pkg::POS_W-1:0] key;
  logic [wssd_pkg::CS_W-1:0]  cs_old, cs_new, v2, leave;
  logic [wssd_pkg::SSD_W-1:0] ssd_nxt;
  logic [ADDR_W-1:0]          wr_addr;

  // Store slot may be overwritten only once the oldest row still subtracted
  // by the sequencer is out of reach.
  assign q_pop = q_vld && !hold_r &&
                 (!q_head.wr ||
                  (({2'b0, q_head.row} + {7'b0, cfg.m}) < ({1'b0, ir_r} + 12'd32)));
  assign wr_addr = {q_head.row[wssd_pkg::SLOT_W-1:0], q_head.col};

  assign virt      = ir_r < {7'b0, cfg.ahead};
  assign x_lt_w    = x_r < cfg.w;
  assign last_x    = virt ? (cfg.w - 11'd1) : (cfg.w + {7'b0, cfg.ahead} - 11'd1);
  assign last_ir   = cfg.h - 11'd1 + {7'b0, cfg.ahead};
  assign irm       = ir_r - {6'b0, cfg.m};
  assign add_en    = x_lt_w && (ir_r < cfg.h);
  assign sub_en    = x_lt_w && (ir_r >= {6'b0, cfg.m}) && (irm < cfg.h);
  assign res       = !virt && (x_r >= {7'b0, cfg.ahead});
  assign frame_end = (ir_r == last_ir) && (x_r == last_x);
  assign key       = base_r + {10'b0, x_r};
  assign room      = ({1'b0, oq_cnt_r} + {3'b0, s2_vld_r && s2_res_r}
                      + {3'b0, s3_vld_r && s3_res_r}) < 4'(wssd_pkg::OQ_DEPTH);
  assign issue     = (a_r > key) && room;

  assign cs_old = (fw_vld_r && (fw_x_r == s2_x_r)) ? fw_v_r : cs_q;
  assign cs_new = (s2_first_r ? '0 : cs_old)
                  + (s2_add_r ? {7'b0, sq_add_q} : '0)
                  - (s2_sub_r ? {7'b0, sq_sub_q} : '0);
  assign v2     = s2_xw_r ? cs_new : '0;

  assign leave   = s3_xm_r ? line_r[cfg.m - 5'd1] : '0;
  assign ssd_nxt = (s3_x0_r ? '0 : ssd_r) + {2'b0, s3_v_r} - {2'b0, leave};

  assign oq_push        = s3_vld_r && s3_res_r;
  assign out_empty      = (oq_cnt_r == '0);
  assign oq_take        = out_pop && !out_empty;
  assign out_window_ssd = oq_mem_r[oq_rp_r].ssd;
  assign out_frame_last = oq_mem_r[oq_rp_r].last;

  // Memories: one write and two reads on the square store, one of each on
  // the column sums; read data registered.
  always_ff @(posedge clk) begin
    if (q_pop && q_head.wr) begin
      sq_mem[wr_addr] <= q_head.sq;
    end
    sq_add_q <= sq_mem[{ir_r[wssd_pkg::SLOT_W-1:0], x_r[wssd_pkg::COL_W-1:0]}];
    sq_sub_q <= sq_mem[{irm[wssd_pkg::SLOT_W-1:0], x_r[wssd_pkg::COL_W-1:0]}];
    cs_q     <= cs_mem[x_r[wssd_pkg::COL_W-1:0]];
    if (s2_vld_r && s2_xw_r) begin
      cs_mem[s2_x_r] <= cs_new;
    end
  end

  // Payload of the pipeline stages.
  always_ff @(posedge clk) begin
    s2_x_r     <= x_r[wssd_pkg::COL_W-1:0];
    s2_xw_r    <= x_lt_w;
    s2_add_r   <= add_en;
    s2_sub_r   <= sub_en;
    s2_first_r <= (ir_r == '0);
    s2_res_r   <= res;
    s2_last_r  <= frame_end;
    s2_x0_r    <= (x_r == '0);
    s2_xm_r    <= (x_r >= {6'b0, cfg.m});
    fw_x_r     <= s2_x_r;
    fw_v_r     <= cs_new;
    s3_v_r     <= v2;
    s3_res_r   <= s2_res_r;
    s3_last_r  <= s2_last_r;
    s3_x0_r    <= s2_x0_r;
    s3_xm_r    <= s2_xm_r;
    if (s3_vld_r) begin
      ssd_r     <= ssd_nxt;
      line_r[0] <= s3_v_r;
      for (int k = 1; k < wssd_pkg::MAX_WINDOW; k++) begin
        line_r[k] <= line_r[k-1];
      end
    end
    if (oq_push) begin
      oq_mem_r[oq_wp_r] <= '{ssd: ssd_nxt, last: s3_last_r};
    end
  end

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      a_r      <= '0;
      base_r   <= '0;
      hold_r   <= 1'b0;
      ir_r     <= '0;
      x_r      <= '0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      fw_vld_r <= 1'b0;
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      s2_vld_r <= issue;
      s3_vld_r <= s2_vld_r;
      fw_vld_r <= s2_vld_r && s2_xw_r;
      if (issue && frame_end) begin
        a_r    <= '0;
        hold_r <= 1'b0;
        ir_r   <= '0;
        x_r    <= '0;
        base_r <= '0;
      end else begin
        if (q_pop) begin
          a_r <= a_r + 21'd1;
          if (q_head.last) begin
            hold_r <= 1'b1;
          end
        end
        if (issue) begin
          if (x_r == last_x) begin
            x_r    <= '0;
            ir_r   <= ir_r + 11'd1;
            base_r <= base_r + {10'b0, cfg.w};
          end else begin
            x_r <= x_r + 11'd1;
          end
        end
      end
      if (oq_push) begin
        oq_wp_r <= oq_wp_r + 2'd1;
      end
      if (oq_take) begin
        oq_rp_r <= oq_rp_r + 2'd1;
      end
      oq_cnt_r <= oq_cnt_r + {2'b0, oq_push} - {2'b0, oq_take};
    end
  end

endmodule

@@ rtl/windowed_sum_squared_difference.sv @@
// Top level of the windowed sum of squared differences block.
// Holds the configuration registers; depends on wssd_pkg, wssd_front, wssd_back.
`timescale 1ns / 1ps
//
//  Channel   Ports                                          Handshake
//  --------  ---------------------------------------------  -------------------------
//  input     in_pixel_first, in_pixel_second, in_flush      in_push, in_full
//  result    out_window_ssd, out_frame_last                 out_pop, out_empty
//  config    cfg_index, cfg_data                            cfg_wr_en (no wait)
//
// A word is taken in every cycle while the front queue has room. The back end walks
// each frame row by row; a row takes frame_width steps, plus window_size - 1 -
// window_size/2 more for rows that produce results, so the sustained rate is
// set by the column sum sequencer and its single read-modify-write port on the
// column sum memory. The result for a window goes from the sequencer through
// the s2 and s3 stages into the result queue once the word that completes it is
// absorbed. Reset is synchronous and active low and needs no clearing pass:
// the stores are never read before they are written in the current frame.
// The front stalls only when its four-word queue fills; the back stops taking
// words while a store row is still needed or while the last word of a frame
// waits for its final results, and a full four-word result queue stalls the
// sequencer.

module windowed_sum_squared_difference (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  input  logic signed [wssd_pkg::PIX_W-1:0] in_pixel_first,
  input  logic signed [wssd_pkg::PIX_W-1:0] in_pixel_second,
  input  logic                              in_flush,
  output logic                              in_full,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [wssd_pkg::SSD_W-1:0]        out_window_ssd,
  output logic                              out_frame_last,
  input  logic                              cfg_wr_en,
  input  logic [wssd_pkg::IDX_W-1:0]        cfg_index,
  input  logic [wssd_pkg::CFG_W-1:0]        cfg_data
);

  logic [wssd_pkg::WIN_W-1:0] win_r;
  logic [wssd_pkg::DIM_W-1:0] width_r, height_r;
  logic [wssd_pkg::WIN_W-1:0] m_c;
  logic [wssd_pkg::DIM_W-1:0] w_c, h_c;
  logic [21:0]                wh, lag_c;
  wssd_pkg::cfg_t             cfg_c, cfg_d_r;
  logic                       restart;
  logic                       q_pop, q_vld;
  wssd_pkg::item_t            q_head;

  // Any write to a known register abandons the frame in progress.
  assign restart = cfg_wr_en && (cfg_index <= wssd_pkg::CFG_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r    <= 5'd3;
      width_r  <= 11'd1024;
      height_r <= 11'd1024;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        wssd_pkg::CFG_WINDOW: win_r    <= cfg_data[wssd_pkg::WIN_W-1:0];
        wssd_pkg::CFG_WIDTH:  width_r  <= cfg_data;
        wssd_pkg::CFG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Out-of-range settings are clamped into the supported range.
  always_comb begin
    m_c = (win_r == '0) ? 5'd1 :
          (win_r > 5'(wssd_pkg::MAX_WINDOW)) ? 5'(wssd_pkg::MAX_WINDOW) : win_r;
    w_c = (width_r == '0) ? 11'd1 :
          (width_r > 11'(wssd_pkg::MAX_WIDTH)) ? 11'(wssd_pkg::MAX_WIDTH) : width_r;
    h_c = (height_r == '0) ? 11'd1 :
          (height_r > 11'(wssd_pkg::MAX_HEIGHT)) ? 11'(wssd_pkg::MAX_HEIGHT) : height_r;
    cfg_c       = '0;
    cfg_c.m     = m_c;
    cfg_c.half  = m_c[wssd_pkg::WIN_W-1:1];
    cfg_c.ahead = 4'(m_c - 5'd1 - {1'b0, m_c[wssd_pkg::WIN_W-1:1]});
    cfg_c.w     = w_c;
    cfg_c.h     = h_c;
    wh          = 22'(w_c) * 22'(h_c);
    lag_c       = 22'(cfg_c.ahead) * 22'(w_c) + 22'(cfg_c.ahead);
    cfg_c.total_last = 21'(wh + lag_c - 22'd1);
  end

  // The derived settings are registered; a word reaches the logic that uses
  // them in the cycle after it is taken, so a write is seen by the very next word.
  always_ff @(posedge clk) begin
    cfg_d_r <= cfg_c;
  end

  wssd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .restart         (restart),
    .cfg             (cfg_d_r),
    .in_push         (in_push),
    .in_pixel_first  (in_pixel_first),
    .in_pixel_second (in_pixel_second),
    .in_flush        (in_flush),
    .in_full         (in_full),
    .q_pop           (q_pop),
    .q_vld           (q_vld),
    .q_head          (q_head)
  );

  wssd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .restart        (restart),
    .cfg            (cfg_d_r),
    .q_vld          (q_vld),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_window_ssd (out_window_ssd),
    .out_frame_last (out_frame_last)
  );

endmodule
